// ===== src/mstt_pkg.sv =====
// Shared types and constants for the multi-slot task timer.
package mstt_pkg;

    localparam int OP_W       = 2;
    localparam int INTERVAL_W = 16;
    localparam int TSLOT_W    = 4;
    localparam int SLOT_OUT_W = 4;
    localparam int STATUS_W   = 2;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [PADDR_W-1:0] ADDR_RUNNING = 3'd0;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_TICK_END,
        PUSH_FULL,
        PUSH_SINGLE
    } push_t;

    typedef struct packed {
        logic  load_in;
        logic  idx_clr;
        logic  idx_inc;
        logic  tick_step;
        logic  add_write;
        push_t push;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic slot_act;
        logic idx_last;
        logic out_ready;
    } dp_stat_t;

endpackage

// ===== src/mstt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mstt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mstt_dp.sv =====
// Datapath of the task timer: slot flags, period and countdown RAMs, result register.
module mstt_dp #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16,
    parameter int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mstt_pkg::OP_W-1:0]         operation,
    input  logic [mstt_pkg::INTERVAL_W-1:0]   interval,
    input  logic                              single_shot,
    input  logic [mstt_pkg::TSLOT_W-1:0]      task_slot,
    input  mstt_pkg::dp_cmd_t                 cmd,
    output mstt_pkg::dp_stat_t                stat,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [mstt_pkg::SLOT_OUT_W-1:0]   slot_out,
    output logic                              fired,
    output logic [mstt_pkg::STATUS_W-1:0]     status,
    output logic                              last
);

    mstt_pkg::op_t                      op_reg;
    logic [TIME_BITS-1:0]               ival_reg;
    logic                               single_reg;
    logic [mstt_pkg::TSLOT_W-1:0]       tslot_reg;
    logic [SW-1:0]                      idx_reg;
    logic [SLOTS-1:0]                   active_reg;
    logic [SLOTS-1:0]                   one_shot_reg;
    logic                               pend_valid_reg;
    logic [SW-1:0]                      pend_slot_reg;
    logic                               out_valid_reg;
    logic [mstt_pkg::SLOT_OUT_W-1:0]    slot_out_reg;
    logic                               fired_reg;
    logic [mstt_pkg::STATUS_W-1:0]      status_reg;
    logic                               last_reg;

    logic [TIME_BITS-1:0] ival_cut;
    logic [TIME_BITS-1:0] ival_load;
    logic [TIME_BITS-1:0] cd_rd;
    logic [TIME_BITS-1:0] period_rd;
    logic [TIME_BITS-1:0] cd_dec;
    logic                 fire;
    logic                 cd_we;
    logic [TIME_BITS-1:0] cd_wdata;
    logic                 out_ready;
    logic                 push;
    logic [SW-1:0]        tslot_idx;
    logic                 tslot_hit;
    logic                 flush_pend;

    assign ival_cut  = TIME_BITS'(interval);
    assign ival_load = (ival_cut == '0) ? TIME_BITS'(1) : ival_cut;

    assign cd_dec = cd_rd - TIME_BITS'(1);
    assign fire   = (cd_dec == '0);

    assign cd_we    = cmd.tick_step || cmd.add_write;
    assign cd_wdata = cmd.add_write ? ival_reg :
                      (fire && !one_shot_reg[idx_reg]) ? period_rd : cd_dec;

    assign tslot_idx = SW'(tslot_reg);
    assign tslot_hit = (int'(tslot_reg) < SLOTS) && active_reg[tslot_idx];

    assign out_ready  = !out_valid_reg || !out_stall;
    assign flush_pend = cmd.tick_step && fire && pend_valid_reg;
    assign push       = flush_pend || cmd.add_write || (cmd.push != mstt_pkg::PUSH_NONE);

    assign stat.op        = op_reg;
    assign stat.slot_act  = active_reg[idx_reg];
    assign stat.idx_last  = (idx_reg == SW'(SLOTS - 1));
    assign stat.out_ready = out_ready;

    mstt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (SLOTS)
    ) u_cd_ram (
        .clk   (clk),
        .we    (cd_we),
        .waddr (idx_reg),
        .wdata (cd_wdata),
        .raddr (idx_reg),
        .rdata (cd_rd)
    );

    mstt_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (SLOTS)
    ) u_period_ram (
        .clk   (clk),
        .we    (cmd.add_write),
        .waddr (idx_reg),
        .wdata (ival_reg),
        .raddr (idx_reg),
        .rdata (period_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            one_shot_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.tick_step && fire)
            begin
                pend_valid_reg <= 1'b1;
                if (one_shot_reg[idx_reg])
                begin
                    active_reg[idx_reg] <= 1'b0;
                end
            end
            if (cmd.add_write)
            begin
                active_reg[idx_reg]   <= 1'b1;
                one_shot_reg[idx_reg] <= single_reg;
            end
            if (cmd.push == mstt_pkg::PUSH_SINGLE && op_reg == mstt_pkg::OP_REMOVE
                && tslot_hit)
            begin
                active_reg[tslot_idx] <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= mstt_pkg::op_t'(operation);
            ival_reg   <= ival_load;
            single_reg <= single_shot;
            tslot_reg  <= task_slot;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + SW'(1);
        end
        if (cmd.tick_step && fire)
        begin
            pend_slot_reg <= idx_reg;
        end
        if (flush_pend)
        begin
            slot_out_reg <= mstt_pkg::SLOT_OUT_W'(pend_slot_reg);
            fired_reg    <= 1'b1;
            status_reg   <= mstt_pkg::ST_OK;
            last_reg     <= 1'b0;
        end
        else if (cmd.add_write)
        begin
            slot_out_reg <= mstt_pkg::SLOT_OUT_W'(idx_reg);
            fired_reg    <= 1'b0;
            status_reg   <= mstt_pkg::ST_OK;
            last_reg     <= 1'b1;
        end
        else
        begin
            unique case (cmd.push)
                mstt_pkg::PUSH_TICK_END:
                begin
                    slot_out_reg <= pend_valid_reg ?
                                    mstt_pkg::SLOT_OUT_W'(pend_slot_reg) : '0;
                    fired_reg    <= pend_valid_reg;
                    status_reg   <= mstt_pkg::ST_OK;
                    last_reg     <= 1'b1;
                end
                mstt_pkg::PUSH_FULL:
                begin
                    slot_out_reg <= '0;
                    fired_reg    <= 1'b0;
                    status_reg   <= mstt_pkg::ST_FULL;
                    last_reg     <= 1'b1;
                end
                mstt_pkg::PUSH_SINGLE:
                begin
                    if (op_reg == mstt_pkg::OP_REMOVE)
                    begin
                        slot_out_reg <= tslot_reg;
                        status_reg   <= tslot_hit ? mstt_pkg::ST_OK : mstt_pkg::ST_INACTIVE;
                    end
                    else
                    begin
                        slot_out_reg <= '0;
                        status_reg   <= mstt_pkg::ST_OK;
                    end
                    fired_reg <= 1'b0;
                    last_reg  <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign slot_out  = slot_out_reg;
    assign fired     = fired_reg;
    assign status    = status_reg;
    assign last      = last_reg;

`ifndef SYNTH
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_ready)
        else $error("result pushed while the output register is held");

    a_one_shot_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick_step && fire && one_shot_reg[idx_reg]) |=> !active_reg[$past(idx_reg)])
        else $error("one-shot slot stayed active after firing");

    a_one_add_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(active_reg) <= $countones($past(active_reg)) + 1))
        else $error("more than one slot claimed at once");
`endif

endmodule

// ===== src/mstt_ctrl.sv =====
// Controller state machine that sequences ticks, adds and removes over the slot table.
module mstt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               running,
    input  mstt_pkg::dp_stat_t stat,
    output mstt_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TICK_RD,
        S_TICK_EV,
        S_TICK_END,
        S_ADD,
        S_SINGLE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.load_in   = 1'b0;
        cmd.idx_clr   = 1'b0;
        cmd.idx_inc   = 1'b0;
        cmd.tick_step = 1'b0;
        cmd.add_write = 1'b0;
        cmd.push      = mstt_pkg::PUSH_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    mstt_pkg::OP_TICK:   state_next = running ? S_TICK_RD : S_TICK_END;
                    mstt_pkg::OP_ADD:    state_next = S_ADD;
                    mstt_pkg::OP_REMOVE: state_next = S_SINGLE;
                    mstt_pkg::OP_NONE:   state_next = S_SINGLE;
                    default:             state_next = S_SINGLE;
                endcase
            end
            S_TICK_RD:
            begin
                if (stat.slot_act)
                begin
                    state_next = S_TICK_EV;
                end
                else if (stat.idx_last)
                begin
                    state_next = S_TICK_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_TICK_EV:
            begin
                if (stat.out_ready)
                begin
                    cmd.tick_step = 1'b1;
                    if (stat.idx_last)
                    begin
                        state_next = S_TICK_END;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_TICK_RD;
                    end
                end
            end
            S_TICK_END:
            begin
                if (stat.out_ready)
                begin
                    cmd.push   = mstt_pkg::PUSH_TICK_END;
                    state_next = S_IDLE;
                end
            end
            S_ADD:
            begin
                if (!stat.slot_act)
                begin
                    if (stat.out_ready)
                    begin
                        cmd.add_write = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (stat.idx_last)
                begin
                    if (stat.out_ready)
                    begin
                        cmd.push   = mstt_pkg::PUSH_FULL;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SINGLE:
            begin
                if (stat.out_ready)
                begin
                    cmd.push   = mstt_pkg::PUSH_SINGLE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

`ifndef SYNTH
    a_eval_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK_EV) |-> stat.slot_act)
        else $error("countdown evaluated for an inactive slot");

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DECODE))
        else $error("accepted beat not decoded next cycle");
`endif

endmodule

// ===== src/multi_slot_task_timer.sv =====
// Top level of the multi-slot task timer: configuration port, controller and datapath.
//
//   channel  | handshake              | beat contents
//   ---------+------------------------+--------------------------------------------
//   in       | in_valid / in_stall    | operation, interval, single_shot, task_slot
//   out      | out_valid / out_stall  | slot_out, fired, status, last
//   config   | psel/penable/pready    | paddr, pwrite, pwdata, prdata (running)
//
// A tick visits every slot in turn while running, and spends an extra evaluation state on each
// active slot, since its countdown is read from and written back to a RAM with a registered read.
// An add scans for the lowest free slot one per cycle. A remove or an unused operation goes
// from decode to a single result state. A stalled output holds the scan where it stands.
// Reset clears the active and one-shot flags, the running register and the controller.
module multi_slot_task_timer #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mstt_pkg::OP_W-1:0]           operation,
    input  logic [mstt_pkg::INTERVAL_W-1:0]     interval,
    input  logic                                single_shot,
    input  logic [mstt_pkg::TSLOT_W-1:0]        task_slot,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mstt_pkg::SLOT_OUT_W-1:0]     slot_out,
    output logic                                fired,
    output logic [mstt_pkg::STATUS_W-1:0]       status,
    output logic                                last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mstt_pkg::PADDR_W-1:0]        paddr,
    input  logic [mstt_pkg::PDATA_W-1:0]        pwdata,
    output logic [mstt_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    logic               running_reg;
    logic               cfg_write;
    mstt_pkg::dp_cmd_t  cmd;
    mstt_pkg::dp_stat_t stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
        end
        else if (cfg_write && paddr == mstt_pkg::ADDR_RUNNING)
        begin
            running_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == mstt_pkg::ADDR_RUNNING) ?
                    mstt_pkg::PDATA_W'(running_reg) : '0;

    mstt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .running  (running_reg),
        .stat     (stat),
        .cmd      (cmd)
    );

    mstt_dp #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .interval    (interval),
        .single_shot (single_shot),
        .task_slot   (task_slot),
        .cmd         (cmd),
        .stat        (stat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .slot_out    (slot_out),
        .fired       (fired),
        .status      (status),
        .last        (last)
    );

endmodule

// ===== tb/sv/mstt_checker.sv =====
// Checker for the multi-slot task timer: tracks the slot table and compares each result beat.
module mstt_checker
    import mstt_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic [INTERVAL_W-1:0] interval,
    input  logic                  single_shot,
    input  logic [TSLOT_W-1:0]    task_slot,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [SLOT_OUT_W-1:0] slot_out,
    input  logic                  fired,
    input  logic [STATUS_W-1:0]   status,
    input  logic                  last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  fired;
        logic [STATUS_W-1:0]   status;
        logic                  last;
    } timer_result_t;

    logic                 slot_active   [SLOTS];
    logic                 slot_one_shot [SLOTS];
    logic [TIME_BITS-1:0] slot_period   [SLOTS];
    logic [TIME_BITS-1:0] slot_countdown[SLOTS];
    logic                 timers_running;

    timer_result_t due_results[$];
    timer_result_t want;
    int            results_seen = 0;

    initial errors = 0;

    task automatic report_mismatch(input string what);
        if (errors < 100)
            $display("[%0t] MISMATCH at result %0d: %s", $time, results_seen, what);
        errors++;
    endtask

    function automatic timer_result_t make_result(input int slot, input logic hit,
                                                  input logic [STATUS_W-1:0] st,
                                                  input logic fin);
        timer_result_t r;
        r.slot   = SLOT_OUT_W'(slot);
        r.fired  = hit;
        r.status = st;
        r.last   = fin;
        return r;
    endfunction

    task automatic predict_timer_beat(input logic [OP_W-1:0] op_bits,
                                      input logic [INTERVAL_W-1:0] ival_in,
                                      input logic one,
                                      input logic [TSLOT_W-1:0] tslot);
        logic [TIME_BITS-1:0] ival;
        timer_result_t        tail;
        int                   hits;
        bit                   placed;
        hits   = 0;
        placed = 0;
        ival   = TIME_BITS'(ival_in);
        case (op_t'(op_bits))
            OP_TICK:
            begin
                if (timers_running)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (slot_active[i])
                        begin
                            slot_countdown[i] = slot_countdown[i] - 1'b1;
                            if (slot_countdown[i] == '0)
                            begin
                                if (slot_one_shot[i])
                                    slot_active[i] = 1'b0;
                                else
                                    slot_countdown[i] = slot_period[i];
                                due_results.push_back(make_result(i, 1'b1, ST_OK, 1'b0));
                                hits++;
                            end
                        end
                    end
                end
                if (hits == 0)
                begin
                    due_results.push_back(make_result(0, 1'b0, ST_OK, 1'b1));
                end
                else
                begin
                    tail      = due_results.pop_back();
                    tail.last = 1'b1;
                    due_results.push_back(tail);
                end
            end
            OP_ADD:
            begin
                if (ival == '0)
                    ival = TIME_BITS'(1);
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!placed && !slot_active[i])
                    begin
                        slot_period[i]    = ival;
                        slot_countdown[i] = ival;
                        slot_one_shot[i]  = one;
                        slot_active[i]    = 1'b1;
                        due_results.push_back(make_result(i, 1'b0, ST_OK, 1'b1));
                        placed = 1;
                    end
                end
                if (!placed)
                    due_results.push_back(make_result(0, 1'b0, ST_FULL, 1'b1));
            end
            OP_REMOVE:
            begin
                if (int'(tslot) < SLOTS && slot_active[tslot])
                begin
                    slot_active[tslot] = 1'b0;
                    due_results.push_back(make_result(int'(tslot), 1'b0, ST_OK, 1'b1));
                end
                else
                begin
                    due_results.push_back(make_result(int'(tslot), 1'b0,
                                                      ST_INACTIVE, 1'b1));
                end
            end
            default:
            begin
                due_results.push_back(make_result(0, 1'b0, ST_OK, 1'b1));
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_active[i]   = 1'b0;
                slot_one_shot[i] = 1'b0;
            end
            timers_running = 1'b0;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "unexpected beat slot %0d fired %0d status %0d last %0d",
                        slot_out, fired, status, last));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (slot_out !== want.slot)
                        report_mismatch($sformatf("slot_out %0d, expected %0d",
                                                  slot_out, want.slot));
                    if (fired !== want.fired)
                        report_mismatch($sformatf("fired %0d, expected %0d", fired, want.fired));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
                end
                results_seen++;
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_RUNNING)
                timers_running = pwdata[0];
            if (in_valid && !in_stall)
                predict_timer_beat(operation, interval, single_shot, task_slot);
            pending <= due_results.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the multi-slot task timer testbench: clock, reset, stimulus and verdict.
module tb
    import mstt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 16;
    localparam int TIME_BITS   = 16;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       operation   = '0;
    logic [INTERVAL_W-1:0] interval    = '0;
    logic                  single_shot = 1'b0;
    logic [TSLOT_W-1:0]    task_slot   = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic                  fired;
    logic [STATUS_W-1:0]   status;
    logic                  last;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [PADDR_W-1:0]    paddr       = '0;
    logic [PDATA_W-1:0]    pwdata      = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int errors;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    bit tight       = 0;

    always #2 clk = ~clk;

    multi_slot_task_timer #(
        .SLOTS    (SLOTS),
        .TIME_BITS(TIME_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .interval   (interval),
        .single_shot(single_shot),
        .task_slot  (task_slot),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .slot_out   (slot_out),
        .fired      (fired),
        .status     (status),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    mstt_checker #(
        .SLOTS    (SLOTS),
        .TIME_BITS(TIME_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .interval   (interval),
        .single_shot(single_shot),
        .task_slot  (task_slot),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .slot_out   (slot_out),
        .fired      (fired),
        .status     (status),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .errors     (errors),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output back-pressure: free-running stretches mixed with stalls, mostly short.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            case ($urandom_range(0, 99)) inside
                [0:39]:
                begin
                    out_stall  <= 1'b0;
                    stall_left <= $urandom_range(1, 30);
                end
                [40:84]:
                begin
                    out_stall  <= 1'b1;
                    stall_left <= $urandom_range(1, 3);
                end
                [85:96]:
                begin
                    out_stall  <= 1'b1;
                    stall_left <= $urandom_range(4, 12);
                end
                default:
                begin
                    out_stall  <= 1'b1;
                    stall_left <= $urandom_range(20, 60);
                end
            endcase
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tight || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_beat(input op_t op, input logic [INTERVAL_W-1:0] ival,
                             input logic one, input logic [TSLOT_W-1:0] tslot);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation   <= op;
        interval    <= ival;
        single_shot <= one;
        task_slot   <= tslot;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained(input bit settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        if (settle)
            repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_running(input logic value);
        wait_drained(1);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_RUNNING;
        pwdata  <= ($urandom() & 32'hFFFF_FFFE) | PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [INTERVAL_W-1:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return INTERVAL_W'($urandom_range(1, 8));
        if (r < 80)
            return INTERVAL_W'($urandom_range(0, 40));
        return INTERVAL_W'($urandom());
    endfunction

    task automatic random_beat(input int w_tick, input int w_add, input int w_remove);
        int  r;
        op_t op;
        r = $urandom_range(0, 99);
        if (r < w_tick)
            op = OP_TICK;
        else if (r < w_tick + w_add)
            op = OP_ADD;
        else if (r < w_tick + w_add + w_remove)
            op = OP_REMOVE;
        else
            op = OP_NONE;
        send_beat(op, pick_interval(), 1'($urandom_range(0, 1)),
                  TSLOT_W'($urandom_range(0, 15)));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(OP_TICK, 16'h0000, 1'b0, 4'd0);
        send_beat(OP_NONE, 16'hFFFF, 1'b1, 4'd15);
        send_beat(OP_REMOVE, 16'h0000, 1'b0, 4'd9);
        send_beat(OP_ADD, 16'h0000, 1'b0, 4'd0);
        send_beat(OP_ADD, 16'hFFFF, 1'b1, 4'd0);
        send_beat(OP_ADD, 16'h0001, 1'b1, 4'd0);
        send_beat(OP_TICK, 16'h0000, 1'b0, 4'd0);
        repeat (13) send_beat(OP_ADD, 16'h8000, 1'b0, 4'd0);
        send_beat(OP_ADD, 16'h0005, 1'b0, 4'd0);
        send_beat(OP_REMOVE, 16'h0000, 1'b0, 4'd15);
        send_beat(OP_REMOVE, 16'h0000, 1'b0, 4'd15);
        write_running(1'b1);
        send_beat(OP_TICK, 16'h0000, 1'b0, 4'd0);
        send_beat(OP_TICK, 16'h0000, 1'b0, 4'd0);
        send_beat(OP_REMOVE, 16'h0000, 1'b0, 4'd1);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_running(1'b1);
                    for (int k = 0; k < 70; k++)
                    begin
                        if (k == 35)
                            wait_drained(0);
                        random_beat(50, 30, 15);
                    end
                end
                1:
                begin
                    write_running(1'b0);
                    repeat (40) random_beat(40, 30, 25);
                end
                2:
                begin
                    write_running(1'b1);
                    tight = 1;
                    repeat (70) random_beat(60, 25, 15);
                    tight = 0;
                end
                3:
                begin
                    write_running(1'b1);
                    repeat (60) random_beat(20, 70, 10);
                end
                4:
                begin
                    write_running(1'b1);
                    for (int k = 0; k < 60; k++)
                    begin
                        if (k == 30)
                            wait_drained(0);
                        random_beat(40, 10, 50);
                    end
                end
                default:
                begin
                    write_running(1'b1);
                    repeat (85) random_beat(50, 30, 15);
                end
            endcase
        end

        wait_drained(1);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
